// ===== src/xssa_pkg.sv =====
// Shared types and constants for the X-stencil sum / arg-max block.
// No dependencies; every other file refers to this package by scoped names.
package xssa_pkg;

  // Grid and data sizing
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int VALUE_W    = 16;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);

  // Configuration port
  localparam int TOTAL_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_TOTAL = 1'b1;

  // Compare width for positions against totals
  localparam int POS_CNT_W  = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
  localparam int CNT_W      = (POS_CNT_W > TOTAL_W) ? POS_CNT_W : TOTAL_W;

  // Result widths
  localparam int OUT_ROW_W  = 10;
  localparam int OUT_COL_W  = 10;
  localparam int SUM_W      = 18;
  localparam int SUM_MAX    = (1 << SUM_W) - 1;

  // Five-term score
  localparam int SCORE_W    = VALUE_W + 3;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Position class of one cell, worked out by the front
  typedef struct packed {
    logic r_ge1;     // row >= 1
    logic r_ge2;     // row >= 2
    logic c_ge1;     // col >= 1
    logic c_ge2;     // col >= 2
    logic r_in;      // row < row total
    logic c_in;      // col < col total
    logic last_row;
    logic last_col;
  } cls_t;

  // One queued cell
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    cls_t               cls;
  } item_t;

endpackage

// ===== src/xssa_front.sv =====
// Front end: configuration registers, raster position tracking and cell classification.
// Depends on xssa_pkg.
module xssa_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [xssa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xssa_pkg::TOTAL_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [xssa_pkg::VALUE_W-1:0]      in_cell_value,
  input  logic                              q_ready,
  output logic                              q_push,
  output xssa_pkg::item_t                   q_item
);

  logic [xssa_pkg::TOTAL_W-1:0] row_total_r, col_total_r;
  logic [xssa_pkg::ROW_W-1:0]   row_pos_r, row_pos_nxt;
  logic [xssa_pkg::COL_W-1:0]   col_pos_r, col_pos_nxt;
  logic [xssa_pkg::CNT_W-1:0]   row_lim, col_lim, row_ext, col_ext;
  logic                         last_row, last_col;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_total_r <= xssa_pkg::TOTAL_W'(1);
      col_total_r <= xssa_pkg::TOTAL_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        xssa_pkg::CFG_ROW_TOTAL: row_total_r <= cfg_wdata;
        xssa_pkg::CFG_COL_TOTAL: col_total_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp totals into 1..MAX
  always_comb begin
    if (row_total_r == '0)
      row_lim = xssa_pkg::CNT_W'(1);
    else if (xssa_pkg::CNT_W'(row_total_r) > xssa_pkg::CNT_W'(xssa_pkg::MAX_ROWS))
      row_lim = xssa_pkg::CNT_W'(xssa_pkg::MAX_ROWS);
    else
      row_lim = xssa_pkg::CNT_W'(row_total_r);

    if (col_total_r == '0)
      col_lim = xssa_pkg::CNT_W'(1);
    else if (xssa_pkg::CNT_W'(col_total_r) > xssa_pkg::CNT_W'(xssa_pkg::MAX_COLS))
      col_lim = xssa_pkg::CNT_W'(xssa_pkg::MAX_COLS);
    else
      col_lim = xssa_pkg::CNT_W'(col_total_r);
  end

  // Classify the current position
  assign row_ext  = xssa_pkg::CNT_W'(row_pos_r);
  assign col_ext  = xssa_pkg::CNT_W'(col_pos_r);
  assign last_row = (row_ext + xssa_pkg::CNT_W'(1)) >= row_lim;
  assign last_col = (col_ext + xssa_pkg::CNT_W'(1)) >= col_lim;

  always_comb begin
    q_item.value        = in_cell_value;
    q_item.row          = row_pos_r;
    q_item.col          = col_pos_r;
    q_item.cls.r_ge1    = row_pos_r != '0;
    q_item.cls.r_ge2    = row_pos_r > xssa_pkg::ROW_W'(1);
    q_item.cls.c_ge1    = col_pos_r != '0;
    q_item.cls.c_ge2    = col_pos_r > xssa_pkg::COL_W'(1);
    q_item.cls.r_in     = row_ext < row_lim;
    q_item.cls.c_in     = col_ext < col_lim;
    q_item.cls.last_row = last_row;
    q_item.cls.last_col = last_col;
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Raster position advance
  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (q_push) begin
      if (!last_col) begin
        col_pos_nxt = col_pos_r + xssa_pkg::COL_W'(1);
      end else begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + xssa_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
    end
  end

endmodule

// ===== src/xssa_queue.sv =====
// Short FIFO that decouples the front end from the stencil back end.
// Depends on xssa_pkg (item_t, QUEUE_DEPTH).
module xssa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  xssa_pkg::item_t push_item,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output xssa_pkg::item_t pop_item
);

  xssa_pkg::item_t               slot_r [xssa_pkg::QUEUE_DEPTH];
  logic [xssa_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [xssa_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign push_ready = count_r != xssa_pkg::QCNT_W'(xssa_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer wrap
  assign wr_ptr_nxt = !do_push ? wr_ptr_r :
                      (wr_ptr_r == xssa_pkg::QPTR_W'(xssa_pkg::QUEUE_DEPTH - 1)) ? '0 :
                      wr_ptr_r + xssa_pkg::QPTR_W'(1);
  assign rd_ptr_nxt = !do_pop ? rd_ptr_r :
                      (rd_ptr_r == xssa_pkg::QPTR_W'(xssa_pkg::QUEUE_DEPTH - 1)) ? '0 :
                      rd_ptr_r + xssa_pkg::QPTR_W'(1);

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)
      count_nxt = count_r + xssa_pkg::QCNT_W'(1);
    else if (do_pop && !do_push)
      count_nxt = count_r - xssa_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/xssa_back.sv =====
// Back end: line buffer memory, diagonal stencil sums, arg-max tree and result register.
// Depends on xssa_pkg.
module xssa_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  xssa_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [xssa_pkg::OUT_ROW_W-1:0]    out_best_row,
  output logic [xssa_pkg::OUT_COL_W-1:0]    out_best_col,
  output logic [xssa_pkg::SUM_W-1:0]        out_best_sum
);

  localparam int LINE_W = 2 * xssa_pkg::VALUE_W;
  localparam int CMP_W  = (xssa_pkg::SCORE_W > xssa_pkg::SUM_W) ?
                          xssa_pkg::SCORE_W : xssa_pkg::SUM_W;

  typedef struct packed {
    logic                         ok;
    logic [xssa_pkg::SCORE_W-1:0] score;
    logic [xssa_pkg::ROW_W-1:0]   row;
    logic [xssa_pkg::COL_W-1:0]   col;
  } cand_t;

  // b wins on a higher score, or on an equal score at a later or equal position
  function automatic cand_t cand_max(input cand_t a, input cand_t b);
    cand_t res;
    res = a;
    if (b.ok && (!a.ok || {b.score, b.row, b.col} >= {a.score, a.row, a.col}))
      res = b;
    return res;
  endfunction

  function automatic logic [xssa_pkg::SCORE_W-1:0] sx(input logic [xssa_pkg::VALUE_W-1:0] x);
    return {{(xssa_pkg::SCORE_W - xssa_pkg::VALUE_W){x[xssa_pkg::VALUE_W-1]}}, x};
  endfunction

  logic advance, pop, s1_fire, out_load;

  // Stage 1: line buffer read data
  logic                           s1_valid_r;
  xssa_pkg::item_t                s1_item_r;
  logic [LINE_W-1:0]              line_mem [xssa_pkg::MAX_COLS];
  logic [LINE_W-1:0]              rd_data_r, fwd_r, entry, wr_data;
  logic                           hit_r;
  logic [xssa_pkg::VALUE_W-1:0]   om, ou, v;
  logic [xssa_pkg::VALUE_W-1:0]   up_d1_r, up_d2_r, mid_d1_r, mid_d2_r, left1_r, left2_r;
  xssa_pkg::cls_t                 k;
  logic [xssa_pkg::ROW_W-1:0]     row_m1;
  logic [xssa_pkg::COL_W-1:0]     col_m1;
  logic [xssa_pkg::SCORE_W-1:0]   sum1, sum2, sum3, sum4;
  cand_t                          cand [4];

  // Later stages
  logic  s2_valid_r, s2_final_r, s3_valid_r, s3_final_r, s4_valid_r, s4_final_r;
  cand_t s2_cand_r [4];
  cand_t s3_cand_r [2];
  cand_t s4_cand_r;
  cand_t best_cur, best_nxt;
  logic [xssa_pkg::SCORE_W-1:0]   best_sum_r;
  logic [xssa_pkg::ROW_W-1:0]     best_row_r;
  logic [xssa_pkg::COL_W-1:0]     best_col_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [xssa_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [xssa_pkg::OUT_COL_W-1:0] out_col_r;
  logic [xssa_pkg::SUM_W-1:0]     out_sum_r, sat_sum;

  // Whole back pipeline holds only while a frame result waits on a full output
  assign advance  = !(s4_valid_r && s4_final_r && out_valid_r && !out_ready);
  assign pop      = advance && q_valid;
  assign q_pop    = pop;
  assign s1_fire  = s1_valid_r && advance;
  assign out_load = s4_valid_r && s4_final_r && advance;

  // Line buffer entry holds {middle row, upper row} for one column
  assign entry   = hit_r ? fwd_r : rd_data_r;
  assign om      = entry[LINE_W-1 -: xssa_pkg::VALUE_W];
  assign ou      = entry[xssa_pkg::VALUE_W-1:0];
  assign v       = s1_item_r.value;
  assign wr_data = {v, om};

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_item_r.col] <= wr_data;
    end
    if (pop) begin
      rd_data_r <= line_mem[q_item.col];
    end
  end

  // Bypass for a read that lands on the column being written the same edge
  always_ff @(posedge clk) begin
    if (advance) begin
      hit_r <= s1_fire && (q_item.col == s1_item_r.col);
      fwd_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= q_item;
    end
  end

  // Window delay registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_d1_r  <= '0;
      up_d2_r  <= '0;
      mid_d1_r <= '0;
      mid_d2_r <= '0;
      left1_r  <= '0;
      left2_r  <= '0;
    end else if (s1_fire) begin
      up_d2_r  <= up_d1_r;
      up_d1_r  <= ou;
      mid_d2_r <= mid_d1_r;
      mid_d1_r <= om;
      left2_r  <= left1_r;
      left1_r  <= v;
    end
  end

  // Four centers that complete with this cell
  assign k      = s1_item_r.cls;
  assign row_m1 = s1_item_r.row - xssa_pkg::ROW_W'(1);
  assign col_m1 = s1_item_r.col - xssa_pkg::COL_W'(1);

  always_comb begin
    // up-left center
    sum1 = sx(mid_d1_r)
         + ((k.r_ge2 && k.c_ge2) ? sx(up_d2_r) : '0)
         + ((k.r_ge2 && k.c_in)  ? sx(ou)      : '0)
         + ((k.r_in  && k.c_ge2) ? sx(left2_r) : '0)
         + ((k.r_in  && k.c_in)  ? sx(v)       : '0);
    // up center, right edge
    sum2 = sx(om)
         + ((k.r_ge2 && k.c_ge1) ? sx(up_d1_r) : '0)
         + ((k.r_in  && k.c_ge1) ? sx(left1_r) : '0);
    // left center, bottom edge
    sum3 = sx(left1_r)
         + ((k.r_ge1 && k.c_ge2) ? sx(mid_d2_r) : '0)
         + ((k.r_ge1 && k.c_in)  ? sx(om)       : '0);
    // current cell, bottom-right corner
    sum4 = sx(v) + ((k.r_ge1 && k.c_ge1) ? sx(mid_d1_r) : '0);

    cand[0].ok    = s1_valid_r && k.r_ge1 && k.c_ge1 && !sum1[xssa_pkg::SCORE_W-1];
    cand[0].score = sum1;
    cand[0].row   = row_m1;
    cand[0].col   = col_m1;
    cand[1].ok    = s1_valid_r && k.r_ge1 && k.last_col && !sum2[xssa_pkg::SCORE_W-1];
    cand[1].score = sum2;
    cand[1].row   = row_m1;
    cand[1].col   = s1_item_r.col;
    cand[2].ok    = s1_valid_r && k.last_row && k.c_ge1 && !sum3[xssa_pkg::SCORE_W-1];
    cand[2].score = sum3;
    cand[2].row   = s1_item_r.row;
    cand[2].col   = col_m1;
    cand[3].ok    = s1_valid_r && k.last_row && k.last_col && !sum4[xssa_pkg::SCORE_W-1];
    cand[3].score = sum4;
    cand[3].row   = s1_item_r.row;
    cand[3].col   = s1_item_r.col;
  end

  // Stage valid / frame-end flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_final_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s3_final_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s4_final_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
      s2_final_r <= s1_valid_r && k.last_row && k.last_col;
      s3_valid_r <= s2_valid_r;
      s3_final_r <= s2_final_r;
      s4_valid_r <= s3_valid_r;
      s4_final_r <= s3_final_r;
    end
  end

  // Max tree: four to two to one
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        s2_cand_r[i] <= cand[i];
      end
      s3_cand_r[0] <= cand_max(s2_cand_r[0], s2_cand_r[1]);
      s3_cand_r[1] <= cand_max(s2_cand_r[2], s2_cand_r[3]);
      s4_cand_r    <= cand_max(s3_cand_r[0], s3_cand_r[1]);
    end
  end

  // Running best against the frame's newest candidate
  always_comb begin
    best_cur.ok    = 1'b1;
    best_cur.score = best_sum_r;
    best_cur.row   = best_row_r;
    best_cur.col   = best_col_r;
    best_nxt       = cand_max(best_cur, s4_cand_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sum_r <= '0;
      best_row_r <= '0;
      best_col_r <= '0;
    end else if (s4_valid_r && advance) begin
      if (s4_final_r) begin
        best_sum_r <= '0;
        best_row_r <= '0;
        best_col_r <= '0;
      end else begin
        best_sum_r <= best_nxt.score;
        best_row_r <= best_nxt.row;
        best_col_r <= best_nxt.col;
      end
    end
  end

  // Result register
  assign sat_sum = (CMP_W'(best_nxt.score) > CMP_W'(xssa_pkg::SUM_MAX)) ?
                   xssa_pkg::SUM_W'(xssa_pkg::SUM_MAX) : xssa_pkg::SUM_W'(best_nxt.score);

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r <= xssa_pkg::OUT_ROW_W'(best_nxt.row);
      out_col_r <= xssa_pkg::OUT_COL_W'(best_nxt.col);
      out_sum_r <= sat_sum;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_best_row = out_row_r;
  assign out_best_col = out_col_r;
  assign out_best_sum = out_sum_r;

endmodule

// ===== src/x_stencil_sum_argmax.sv =====
// A frame's result shows on out_valid after its last cell passes the queue, stages 1 to 4 and the result register.
// Throughput: one cell per cycle sustained, with the line buffer read and written every
// cycle; the back pipeline holds only while a finished result waits on out_ready and the
// next frame also ends.
// Reset (rst_n, synchronous, active low): positions, best score and pipeline cleared,
// both totals set to 1; the line buffer is not cleared.
module x_stencil_sum_argmax (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [xssa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xssa_pkg::TOTAL_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [xssa_pkg::VALUE_W-1:0]      in_cell_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [xssa_pkg::OUT_ROW_W-1:0]    out_best_row,
  output logic [xssa_pkg::OUT_COL_W-1:0]    out_best_col,
  output logic [xssa_pkg::SUM_W-1:0]        out_best_sum
);

  logic            push, push_ready, pop, pop_valid;
  xssa_pkg::item_t push_item, pop_item;

  // Classify incoming cells
  xssa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_value (in_cell_value),
    .q_ready       (push_ready),
    .q_push        (push),
    .q_item        (push_item)
  );

  // Decoupling queue
  xssa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  // Stencil sums and arg-max
  xssa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (pop_valid),
    .q_item       (pop_item),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_best_row (out_best_row),
    .out_best_col (out_best_col),
    .out_best_sum (out_best_sum)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for x_stencil_sum_argmax: directed and random grid frames
// go through a cycle-free model of the stencil arg-max, under bursty input and output stalls.
// Depends on xssa_pkg and the RTL top level x_stencil_sum_argmax.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One frame result as the block reports it
  typedef struct packed {
    logic [xssa_pkg::OUT_ROW_W-1:0] row_idx;
    logic [xssa_pkg::OUT_COL_W-1:0] col_idx;
    logic [xssa_pkg::SUM_W-1:0]     score;
  } argmax_t;

  // Content styles for random frames
  typedef enum int {MIX_CELLS, NEG_CELLS, TIE_CELLS} fill_kind_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [xssa_pkg::CFG_IDX_W-1:0] cfg_index = xssa_pkg::CFG_ROW_TOTAL;
  logic [xssa_pkg::TOTAL_W-1:0]   cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [xssa_pkg::VALUE_W-1:0]   in_cell_value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [xssa_pkg::OUT_ROW_W-1:0] out_best_row;
  logic [xssa_pkg::OUT_COL_W-1:0] out_best_col;
  logic [xssa_pkg::SUM_W-1:0]     out_best_sum;

  x_stencil_sum_argmax dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_best_row  (out_best_row),
    .out_best_col  (out_best_col),
    .out_best_sum  (out_best_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  logic [xssa_pkg::VALUE_W-1:0] cell_queue [$];
  argmax_t                      argmax_expected [$];

  int errors = 0;
  int cells_in = 0;
  int results_seen = 0;
  int grid_changes = 0;

  // Predictor state: totals as written, line buffers, left/diagonal taps, best so far
  logic [xssa_pkg::TOTAL_W-1:0]        rows_cfg, cols_cfg;
  logic signed [xssa_pkg::VALUE_W-1:0] upper_mem [xssa_pkg::MAX_COLS];
  logic signed [xssa_pkg::VALUE_W-1:0] middle_mem [xssa_pkg::MAX_COLS];
  logic signed [xssa_pkg::VALUE_W-1:0] left1, left2, up_d1, up_d2, mid_d1, mid_d2;
  int unsigned                         pos_row, pos_col, win_row, win_col;
  int                                  win_sum;

  function automatic int unsigned eff_total(input int unsigned t, input int unsigned cap);
    if (t < 1) return 1;
    if (t > cap) return cap;
    return t;
  endfunction

  // Score one center; neighbors outside the grid drop out, later ties win
  task automatic weigh_centre(input int unsigned cr, input int unsigned cc,
                              input int unsigned nr, input int unsigned nc,
                              input int centre, input int ul, input int ur,
                              input int dl, input int dr);
    bit up, down, lf, rt;
    int s;
    up = (cr >= 1);
    down = (cr + 1 < nr);
    lf = (cc >= 1);
    rt = (cc + 1 < nc);
    s = centre;
    if (up && lf) s += ul;
    if (up && rt) s += ur;
    if (down && lf) s += dl;
    if (down && rt) s += dr;
    if (s < 0) return;
    if (s > win_sum ||
        (s == win_sum && (cr > win_row || (cr == win_row && cc >= win_col)))) begin
      win_sum = s;
      win_row = cr;
      win_col = cc;
    end
  endtask

  // Advance the grid by one cell; a frame's last cell queues its result
  task automatic score_cell(input logic [xssa_pkg::VALUE_W-1:0] raw);
    int unsigned nr, nc, r, c;
    bit last_c, last_r;
    int v, ou, om;
    argmax_t res;
    nr = eff_total(32'(rows_cfg), xssa_pkg::MAX_ROWS);
    nc = eff_total(32'(cols_cfg), xssa_pkg::MAX_COLS);
    r = pos_row;
    c = pos_col;
    last_c = (c + 1 >= nc);
    last_r = (r + 1 >= nr);
    v = int'($signed(raw));
    ou = int'(upper_mem[c]);
    om = int'(middle_mem[c]);
    upper_mem[c] = middle_mem[c];
    middle_mem[c] = raw;

    // Centers whose last neighbor just arrived
    if (r >= 1 && c >= 1)
      weigh_centre(r - 1, c - 1, nr, nc, int'(mid_d1), int'(up_d2), ou, int'(left2), v);
    if (r >= 1 && last_c)
      weigh_centre(r - 1, c, nr, nc, om, int'(up_d1), 0, int'(left1), 0);
    if (last_r && c >= 1)
      weigh_centre(r, c - 1, nr, nc, int'(left1), int'(mid_d2), om, 0, 0);
    if (last_r && last_c)
      weigh_centre(r, c, nr, nc, v, int'(mid_d1), 0, 0, 0);

    up_d2 = up_d1;
    up_d1 = xssa_pkg::VALUE_W'(ou);
    mid_d2 = mid_d1;
    mid_d1 = xssa_pkg::VALUE_W'(om);
    left2 = left1;
    left1 = raw;

    if (!last_c) begin
      pos_col = c + 1;
      return;
    end
    pos_col = 0;
    if (!last_r) begin
      pos_row = r + 1;
      return;
    end
    pos_row = 0;
    res.row_idx = xssa_pkg::OUT_ROW_W'(win_row);
    res.col_idx = xssa_pkg::OUT_COL_W'(win_col);
    res.score = xssa_pkg::SUM_W'((win_sum > xssa_pkg::SUM_MAX) ? xssa_pkg::SUM_MAX : win_sum);
    argmax_expected.push_back(res);
    win_row = 0;
    win_col = 0;
    win_sum = 0;
  endtask

  // Input driver: bursts of beats from the queue, random gaps in between
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_cell_value <= '0;
      burst_left = 0;
      gap_left = $urandom_range(0, 4);
    end else begin
      if (in_valid && in_ready) begin
        score_cell(in_cell_value);
        cells_in++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cell_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_cell_value <= cell_queue.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls at random, but never in the first quarter of each ready_phase period
  int stall_left, ready_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      ready_phase = 0;
    end else begin
      ready_phase = (ready_phase + 1) % 512;
      if (ready_phase < 128) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Result monitor: each beat against the oldest expectation
  argmax_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (argmax_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d col %0d sum %0d", $time,
                 out_best_row, out_best_col, out_best_sum);
      end else begin
        want = argmax_expected.pop_front();
        if (out_best_row !== want.row_idx) begin
          errors++;
          $display("%0t: best_row expected %0d got %0d", $time, want.row_idx, out_best_row);
        end
        if (out_best_col !== want.col_idx) begin
          errors++;
          $display("%0t: best_col expected %0d got %0d", $time, want.col_idx, out_best_col);
        end
        if (out_best_sum !== want.score) begin
          errors++;
          $display("%0t: best_sum expected %0d got %0d", $time, want.score, out_best_sum);
        end
      end
    end
  end

  // Wait until nothing is queued, in flight or expected, then let the pipeline drain
  task automatic settle();
    do @(negedge clk);
    while (cell_queue.size() != 0 || in_valid || argmax_expected.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [xssa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [xssa_pkg::TOTAL_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == xssa_pkg::CFG_ROW_TOTAL) rows_cfg = val;
    else cols_cfg = val;
  endtask

  task automatic set_grid(input int unsigned rows, input int unsigned cols);
    settle();
    cfg_write(xssa_pkg::CFG_ROW_TOTAL, xssa_pkg::TOTAL_W'(rows));
    cfg_write(xssa_pkg::CFG_COL_TOTAL, xssa_pkg::TOTAL_W'(cols));
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_changes++;
  endtask

  function automatic logic [xssa_pkg::VALUE_W-1:0] pick_cell(input fill_kind_t kind);
    case (kind)
      NEG_CELLS: return xssa_pkg::VALUE_W'(-$urandom_range(1, 32768));
      TIE_CELLS: return xssa_pkg::VALUE_W'($urandom_range(0, 2));
      default: begin
        case ($urandom_range(0, 3))
          0: return xssa_pkg::VALUE_W'($urandom);
          1: begin
            case ($urandom_range(0, 4))
              0: return 16'h7FFF;
              1: return 16'h8000;
              2: return 16'hFFFF;
              3: return 16'h0001;
              default: return 16'h0000;
            endcase
          end
          default: return xssa_pkg::VALUE_W'($urandom_range(0, 12) - 4);
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [xssa_pkg::VALUE_W-1:0] shrink_cells [7];
    int unsigned n;
    int small_cells, small_frames;
    fill_kind_t kind;

    // Predictor starts from the reset state
    rows_cfg = xssa_pkg::TOTAL_W'(1);
    cols_cfg = xssa_pkg::TOTAL_W'(1);
    pos_row = 0;
    pos_col = 0;
    win_row = 0;
    win_col = 0;
    win_sum = 0;
    left1 = '0;
    left2 = '0;
    up_d1 = '0;
    up_d2 = '0;
    mid_d1 = '0;
    mid_d2 = '0;
    for (int i = 0; i < xssa_pkg::MAX_COLS; i++) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    shrink_cells = '{16'd100, 16'hFFFB, 16'd7, 16'h7FFF, 16'd3, 16'd9, 16'd2};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-cell frames on the reset totals
    cell_queue.push_back(16'h7FFF);
    cell_queue.push_back(16'h8000);
    cell_queue.push_back(16'h0000);
    // Full X at the largest value, then an all-negative grid
    set_grid(3, 3);
    repeat (9) cell_queue.push_back(16'h7FFF);
    set_grid(2, 2);
    repeat (4) cell_queue.push_back(16'h8000);
    // Single row of zeros: last tie wins
    set_grid(1, 3);
    repeat (3) cell_queue.push_back(16'h0000);
    // Totals shrunk in the middle of a frame
    set_grid(3, 5);
    foreach (shrink_cells[i]) cell_queue.push_back(shrink_cells[i]);
    set_grid(0, 2);
    cell_queue.push_back(16'h0005);

    // Tall column: largest row totals, then cut short mid-frame
    set_grid(2047, 1);
    repeat (20) cell_queue.push_back(pick_cell(MIX_CELLS));
    set_grid(1024, 1);
    repeat (20) cell_queue.push_back(pick_cell(MIX_CELLS));
    set_grid(0, 1);
    cell_queue.push_back(pick_cell(MIX_CELLS));

    // Widest row, clamped column total
    set_grid(0, 2047);
    repeat (1024) cell_queue.push_back(pick_cell(MIX_CELLS));

    // Random small frames, often back to back on the same totals
    small_cells = 0;
    small_frames = 0;
    while (small_cells < 350 || small_frames < 30) begin
      if (small_frames == 0 || $urandom_range(0, 9) < 6)
        set_grid($urandom_range(0, 6), $urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1: kind = NEG_CELLS;
        2, 3: kind = TIE_CELLS;
        default: kind = MIX_CELLS;
      endcase
      n = eff_total(32'(rows_cfg), xssa_pkg::MAX_ROWS) *
          eff_total(32'(cols_cfg), xssa_pkg::MAX_COLS);
      repeat (n) cell_queue.push_back(pick_cell(kind));
      small_cells += n;
      small_frames++;
    end

    settle();
    repeat (8) @(posedge clk);
    if (argmax_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, argmax_expected.size());
    end
    $display("Run covered %0d cells over %0d grid settings, %0d frame results checked",
             cells_in, grid_changes, results_seen);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: watchdog expired before the run finished", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
